// ===== src/bpvr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpvr_pkg
// Shared widths, constants, register indexes and types for the boost
// converter PI(D) voltage regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpvr_pkg;

    // adc and conversion to q8 volts (35:1 divider, 3.3 V reference)
    localparam int      ADC_BITS  = 12;
    localparam longint  ADC_FULL  = (64'd1 << ADC_BITS) - 64'd1;
    localparam longint  VOLT_NUM  = 64'd30277632;
    localparam longint  SCALE     = (VOLT_NUM + ADC_FULL / 2) / ADC_FULL;
    localparam int      SCALE_W   = $clog2(SCALE + 1);
    localparam int      CONV_SHIFT = 10;

    // register field widths
    localparam int GAIN_W = 12;
    localparam int TGT_W  = 7;

    // datapath widths
    localparam int VOLT_W = 16;
    localparam int ERR_W  = 17;
    localparam int INT_W  = 20;
    localparam int DER_W  = 18;
    localparam int DUTY_W = 8;
    localparam int MA_W   = ((SCALE_W > GAIN_W) ? SCALE_W : GAIN_W) + 1;
    localparam int MB_W   = 21;
    localparam int P_W    = MA_W + MB_W;
    localparam int ACC_W  = P_W + 2;

    localparam int INT_LIMIT = 256000;
    localparam int DUTY_MAX  = 200;
    localparam int SAFE_CAP  = 36;
    localparam int FULL_CAP  = 75;
    localparam int OUT_SHIFT = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] REG_SHOCK_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd5;

    typedef struct packed {
        logic              shock_en;
        logic [TGT_W-1:0]  target;
        logic              safe_mode;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ERR,
        ST_MULP,
        ST_MULI,
        ST_MULD,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_SCALE,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef struct packed {
        logic     take_in;
        logic     clear_state;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     err_upd;
        logic     acc_load;
        logic     acc_add;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic gated;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/bpvr_cfg.sv =====
// ----------------------------------------------------------------------------
// bpvr_cfg
// Configuration register file: enable, target, safe mode and loop gains.
// ----------------------------------------------------------------------------
`default_nettype none

module bpvr_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bpvr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bpvr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bpvr_pkg::t_cfg                      o_cfg
);
    import bpvr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHOCK_EN:  n_cfg.shock_en  = i_cfg_data[0];
                REG_TARGET:    n_cfg.target    = i_cfg_data[TGT_W-1:0];
                REG_SAFE_MODE: n_cfg.safe_mode = i_cfg_data[0];
                REG_GAIN_P:    n_cfg.gain_p    = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    n_cfg.gain_i    = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    n_cfg.gain_d    = i_cfg_data[GAIN_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shock_en  <= 1'b0;
            r_cfg.target    <= '0;
            r_cfg.safe_mode <= 1'b1;
            r_cfg.gain_p    <= GAIN_W'(256);
            r_cfg.gain_i    <= GAIN_W'(26);
            r_cfg.gain_d    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpvr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpvr_ctrl
// Sequencer for one control tick: conversion, error update, three products on
// the shared multiplier, accumulation and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module bpvr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire bpvr_pkg::t_dp_sts i_sts,
    output bpvr_pkg::t_dp_cmd      o_cmd
);
    import bpvr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_SCALE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    if (i_sts.gated) begin
                        o_cmd.clear_state = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SCALE;
                n_state = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.err_upd = 1'b1;
                n_state = ST_MULP;
            end
            ST_MULP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state = ST_MULI;
            end
            ST_MULI: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_I;
                o_cmd.acc_load = 1'b1;
                n_state = ST_MULD;
            end
            ST_MULD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
                o_cmd.acc_add = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/bpvr_dp.sv =====
// ----------------------------------------------------------------------------
// bpvr_dp
// Regulator datapath: shared signed multiplier, error and clamped integral,
// derivative, accumulator, duty saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpvr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bpvr_pkg::t_cfg                i_cfg,
    input  wire bpvr_pkg::t_dp_cmd             i_cmd,
    output bpvr_pkg::t_dp_sts                  o_sts,
    input  wire logic [bpvr_pkg::ADC_BITS-1:0] i_feedback_sample,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [bpvr_pkg::DUTY_W-1:0]        o_duty,
    output logic                               o_regulating,
    output logic                               o_integral_limited
);
    import bpvr_pkg::*;

    localparam logic signed [INT_W:0]   LIM_POS  = (INT_W+1)'(INT_LIMIT);
    localparam logic signed [INT_W:0]   LIM_NEG  = -LIM_POS;
    localparam logic signed [ACC_W-1:0] DUTY_SAT = ACC_W'(DUTY_MAX) << OUT_SHIFT;

    logic [ADC_BITS-1:0]     r_raw;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W-1:0] r_last_err;
    logic signed [INT_W-1:0] r_int;
    logic signed [DER_W-1:0] r_deriv;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_run;
    logic                    r_limited;
    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_duty;
    logic                    r_out_reg;
    logic                    r_out_lim;

    logic [TGT_W-1:0]        cap;
    logic [TGT_W-1:0]        tgt;
    logic [VOLT_W-1:0]       volts;
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W:0]   sum_ext;
    logic signed [INT_W-1:0] sum_clamped;
    logic                    sum_limited;
    logic signed [DER_W-1:0] deriv;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   product;
    logic signed [ACC_W-1:0] prod_ext;
    logic [DUTY_W-1:0]       n_duty;

    assign o_sts = '{gated:    (!i_cfg.shock_en || (i_cfg.target == '0)),
                     out_free: (!r_out_valid || !i_out_stall)};

    // target capped by mode, then error against the converted sample
    always_comb begin
        cap   = i_cfg.safe_mode ? TGT_W'(SAFE_CAP) : TGT_W'(FULL_CAP);
        tgt   = (i_cfg.target > cap) ? cap : i_cfg.target;
        volts = r_prod[CONV_SHIFT +: VOLT_W];
        err   = $signed({2'b00, tgt, 8'h00}) - $signed({1'b0, volts});
        sum_ext = {r_int[INT_W-1], r_int} + {{(INT_W+1-ERR_W){err[ERR_W-1]}}, err};
        sum_limited = 1'b0;
        sum_clamped = sum_ext[INT_W-1:0];
        if (sum_ext > LIM_POS) begin
            sum_clamped = LIM_POS[INT_W-1:0];
            sum_limited = 1'b1;
        end else if (sum_ext < LIM_NEG) begin
            sum_clamped = LIM_NEG[INT_W-1:0];
            sum_limited = 1'b1;
        end
        deriv = {err[ERR_W-1], err} - {r_last_err[ERR_W-1], r_last_err};
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SCALE: begin
                mul_a = MA_W'(SCALE);
                mul_b = {{(MB_W-ADC_BITS){1'b0}}, r_raw};
            end
            MUL_P: begin
                mul_a = {{(MA_W-GAIN_W){1'b0}}, i_cfg.gain_p};
                mul_b = {{(MB_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            MUL_I: begin
                mul_a = {{(MA_W-GAIN_W){1'b0}}, i_cfg.gain_i};
                mul_b = {{(MB_W-INT_W){r_int[INT_W-1]}}, r_int};
            end
            default: begin
                mul_a = {{(MA_W-GAIN_W){1'b0}}, i_cfg.gain_d};
                mul_b = {{(MB_W-DER_W){r_deriv[DER_W-1]}}, r_deriv};
            end
        endcase
        product  = mul_a * mul_b;
        prod_ext = {{(ACC_W-P_W){r_prod[P_W-1]}}, r_prod};
    end

    always_comb begin
        if (r_acc >= DUTY_SAT) begin
            n_duty = DUTY_W'(DUTY_MAX);
        end else if (r_acc[ACC_W-1]) begin
            n_duty = '0;
        end else begin
            n_duty = r_acc[OUT_SHIFT +: DUTY_W];
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int      <= '0;
            r_last_err <= '0;
        end else if (i_cmd.clear_state) begin
            r_int      <= '0;
            r_last_err <= '0;
        end else if (i_cmd.err_upd) begin
            r_int      <= sum_clamped;
            r_last_err <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_raw     <= i_feedback_sample;
            r_run     <= !o_sts.gated;
            r_limited <= 1'b0;
        end
        if (i_cmd.err_upd) begin
            r_err     <= err;
            r_deriv   <= deriv;
            r_limited <= sum_limited;
        end
        if (i_cmd.mul_en) begin
            r_prod <= product;
        end
        if (i_cmd.clear_state) begin
            r_acc <= '0;
        end else if (i_cmd.acc_load) begin
            r_acc <= prod_ext;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + prod_ext;
        end
        if (i_cmd.out_load) begin
            r_duty    <= n_duty;
            r_out_reg <= r_run;
            r_out_lim <= r_limited;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_duty             = r_duty;
    assign o_regulating       = r_out_reg;
    assign o_integral_limited = r_out_lim;

endmodule

`default_nettype wire

// ===== src/boost_pi_voltage_regulator.sv =====
// Sequence: when the loop runs, an accepted sample goes through convert,
//   error/integral update, three products on the shared multiplier,
//   accumulate, saturate; when gated off it goes straight to the result load.
// Flow: one sample in flight at a time on the single shared multiplier; the
//   next sample is taken after the result register loads, past any output stall.
// Reset: synchronous, active low; clears registers to defaults and the loop state.
// ----------------------------------------------------------------------------
// boost_pi_voltage_regulator
// PI(D) boost-voltage regulator with integral clamp and duty saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module boost_pi_voltage_regulator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bpvr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bpvr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [bpvr_pkg::ADC_BITS-1:0]   i_feedback_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [bpvr_pkg::DUTY_W-1:0]          o_duty,
    output logic                                 o_regulating,
    output logic                                 o_integral_limited
);
    import bpvr_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    bpvr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bpvr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpvr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_feedback_sample  (i_feedback_sample),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_duty             (o_duty),
        .o_regulating       (o_regulating),
        .o_integral_limited (o_integral_limited)
    );

endmodule

`default_nettype wire

// ===== src/bpvr_checker.sv =====
// ----------------------------------------------------------------------------
// bpvr_checker
// Port-level checks for the regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpvr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [bpvr_pkg::DUTY_W-1:0]     o_duty,
    input wire logic                            o_regulating,
    input wire logic                            o_integral_limited
);
    import bpvr_pkg::*;

    // a result beat is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // gated beats carry zero duty and no clamp flag
    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_regulating |-> (o_duty == '0) && !o_integral_limited)
        else $error("gated beat with nonzero duty or flag");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty <= DUTY_W'(DUTY_MAX)))
        else $error("duty above limit");

    // one sample in flight at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second sample taken back to back");

endmodule

bind boost_pi_voltage_regulator bpvr_checker u_bpvr_checker (.*);

`default_nettype wire

// ===== test/boost_pi_voltage_regulator_test.sv =====
// ----------------------------------------------------------------------------
// boost_pi_voltage_regulator_test
// Self-checking bench for the boost regulator. A short directed table walks
// reset values, field extremes, target caps, masked register bits, spare
// indexes and the integral clamp; random phases then change the register
// settings and feed noise, near-setpoint samples and integral wind-up runs.
// Each result beat is checked against the in-bench loop model or a fixed table value.
// ----------------------------------------------------------------------------
module boost_pi_voltage_regulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpvr_pkg::*;

    localparam int ADC_MAX         = (1 << ADC_BITS) - 1;
    localparam int COUNT_SCALE     = (30277632 + ADC_MAX / 2) / ADC_MAX;
    localparam int VOLT_ONE        = 256;
    localparam int INT_CLAMP       = 1000 * VOLT_ONE;
    localparam int DUTY_TOP        = 200;
    localparam int SAFE_VOLTS      = 36;
    localparam int FULL_VOLTS      = 75;
    localparam int RANDOM_ITEMS    = 2000;
    localparam int QUIET_TAIL      = 200;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_CYCLES = 2000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              regulating;
        logic              limited;
    } t_duty_beat;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [4:0]            reps;
        logic                  typed;
        t_duty_beat            want;
    } t_plan_row;

    localparam t_duty_beat GATED_OFF = '{duty: 8'd0, regulating: 1'b0, limited: 1'b0};
    localparam t_duty_beat ZERO_GAIN = '{duty: 8'd0, regulating: 1'b1, limited: 1'b0};

    localparam int NROWS = 28;
    localparam t_plan_row PLAN [NROWS] = '{
        '{ROW_SAMPLE, '0,            12'd0,    5'd1,  1'b1, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd4095, 5'd1,  1'b1, GATED_OFF},
        '{ROW_WRITE,  REG_SHOCK_EN,  12'hFFF,  5'd0,  1'b0, GATED_OFF},
        // enabled but target still zero
        '{ROW_SAMPLE, '0,            12'hABC,  5'd1,  1'b1, GATED_OFF},
        // upper bits dropped, target 36
        '{ROW_WRITE,  REG_TARGET,    12'hFA4,  5'd0,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd0,    5'd1,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd4095, 5'd1,  1'b0, GATED_OFF},
        // above the safe cap
        '{ROW_WRITE,  REG_TARGET,    12'h07F,  5'd0,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd1000, 5'd1,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_SAFE_MODE, 12'hFFE,  5'd0,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd0,    5'd1,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_GAIN_P,    12'd4095, 5'd0,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_GAIN_I,    12'd4095, 5'd0,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_GAIN_D,    12'd4095, 5'd0,  1'b0, GATED_OFF},
        // spare indexes must not touch anything
        '{ROW_WRITE,  REG_SPARE_6,   12'hFFF,  5'd0,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_SPARE_7,   12'h000,  5'd0,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd0,    5'd1,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd4095, 5'd1,  1'b0, GATED_OFF},
        // full error each tick, runs the integral into its clamp
        '{ROW_SAMPLE, '0,            12'd0,    5'd14, 1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd4095, 5'd1,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_SHOCK_EN,  12'd0,    5'd0,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd2048, 5'd1,  1'b1, GATED_OFF},
        '{ROW_WRITE,  REG_SHOCK_EN,  12'd1,    5'd0,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_GAIN_P,    12'd0,    5'd0,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_GAIN_I,    12'd0,    5'd0,  1'b0, GATED_OFF},
        '{ROW_WRITE,  REG_GAIN_D,    12'd0,    5'd0,  1'b0, GATED_OFF},
        '{ROW_SAMPLE, '0,            12'd4095, 5'd1,  1'b1, ZERO_GAIN},
        '{ROW_SAMPLE, '0,            12'd0,    5'd1,  1'b1, ZERO_GAIN}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [ADC_BITS-1:0]   i_feedback_sample;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DUTY_W-1:0]     o_duty;
    logic                  o_regulating;
    logic                  o_integral_limited;

    // model copy of the registers and loop state
    logic                     cfg_shock;
    logic [TGT_W-1:0]         cfg_target;
    logic                     cfg_safe;
    logic [GAIN_W-1:0]        cfg_gain_p;
    logic [GAIN_W-1:0]        cfg_gain_i;
    logic [GAIN_W-1:0]        cfg_gain_d;
    logic signed [INT_W-1:0]  pred_integral;
    logic signed [ERR_W-1:0]  pred_last_err;

    t_duty_beat duty_expected_q [$];
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    int         idle_odds    = 0;
    int         stall_left   = 0;

    boost_pi_voltage_regulator u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_feedback_sample  (i_feedback_sample),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_duty             (o_duty),
        .o_regulating       (o_regulating),
        .o_integral_limited (o_integral_limited)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int sample_volts(input logic [ADC_BITS-1:0] s);
        return (int'(s) * COUNT_SCALE) >>> 10;
    endfunction

    function automatic int capped_target();
        int cap;
        cap = cfg_safe ? SAFE_VOLTS : FULL_VOLTS;
        return (int'(cfg_target) > cap) ? cap : int'(cfg_target);
    endfunction

    // one control tick of the loop, advances the model state
    function automatic t_duty_beat regulate_tick(input logic [ADC_BITS-1:0] s);
        t_duty_beat r;
        int         err;
        int         total;
        int         deriv;
        longint     acc;
        r = '0;
        if (!cfg_shock || cfg_target == '0) begin
            pred_integral = '0;
            pred_last_err = '0;
            return r;
        end
        err   = capped_target() * VOLT_ONE - sample_volts(s);
        total = int'(pred_integral) + err;
        if (total > INT_CLAMP) begin
            total     = INT_CLAMP;
            r.limited = 1'b1;
        end else if (total < -INT_CLAMP) begin
            total     = -INT_CLAMP;
            r.limited = 1'b1;
        end
        deriv = err - int'(pred_last_err);
        acc = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * total
            + longint'(cfg_gain_d) * deriv;
        if (acc >= (longint'(DUTY_TOP) << 16))
            r.duty = DUTY_W'(DUTY_TOP);
        else if (acc < 0)
            r.duty = '0;
        else
            r.duty = DUTY_W'(acc >>> 16);
        r.regulating  = 1'b1;
        pred_integral = INT_W'(total);
        pred_last_err = ERR_W'(err);
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns mismatch: %0s", $time, msg);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (duty_expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SHOCK_EN:  cfg_shock  = data[0];
            REG_TARGET:    cfg_target = data[TGT_W-1:0];
            REG_SAFE_MODE: cfg_safe   = data[0];
            REG_GAIN_P:    cfg_gain_p = data[GAIN_W-1:0];
            REG_GAIN_I:    cfg_gain_i = data[GAIN_W-1:0];
            REG_GAIN_D:    cfg_gain_d = data[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // valid stays high on return so back-to-back beats need no gap
    task automatic send_sample(input logic [ADC_BITS-1:0] s, input t_duty_beat want);
        i_cfg_valid = 1'b0;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_feedback_sample = s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        duty_expected_q.push_back(want);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0 && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_duty_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (duty_expected_q.size() == 0) begin
                    log_mismatch($sformatf("result beat with nothing pending, duty %0d",
                                           o_duty));
                end else begin
                    want = duty_expected_q.pop_front();
                    if (o_duty !== want.duty)
                        log_mismatch($sformatf("duty expected %0d got %0d",
                                               want.duty, o_duty));
                    if (o_regulating !== want.regulating)
                        log_mismatch($sformatf("regulating expected %0b got %0b",
                                               want.regulating, o_regulating));
                    if (o_integral_limited !== want.limited)
                        log_mismatch($sformatf("integral_limited expected %0b got %0b",
                                               want.limited, o_integral_limited));
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_plan_row             row;
        t_duty_beat            want;
        int                    items_sent;
        int                    kind;
        int                    n;
        int                    tgt256;
        int                    push;
        int                    need;
        int                    hits;
        int                    pick;
        int                    err;
        int                    sp;
        bit                    upward;
        bit                    found;
        logic [ADC_BITS-1:0]   s;
        logic [ADC_BITS-1:0]   push_s;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;

        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_feedback_sample = '0;
        cfg_shock         = 1'b0;
        cfg_target        = '0;
        cfg_safe          = 1'b1;
        cfg_gain_p        = GAIN_W'(256);
        cfg_gain_i        = GAIN_W'(26);
        cfg_gain_d        = '0;
        pred_integral     = '0;
        pred_last_err     = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_odds = 4;
        for (int r = 0; r < NROWS; r++) begin
            row = PLAN[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.data);
            end else begin
                repeat (row.reps) begin
                    want = regulate_tick(ADC_BITS'(row.data));
                    if (row.typed)
                        want = row.want;
                    send_sample(ADC_BITS'(row.data), want);
                end
            end
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // 0: gated off, 1..3: integral wind-up, else noise and near-setpoint samples
            kind = $urandom_range(0, 9);
            if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                idle_odds = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 12;
                    default: idle_odds = 3;
                endcase
            end

            for (int k = REG_SHOCK_EN; k <= REG_GAIN_D; k++) begin
                if ($urandom_range(0, 1) == 0) begin
                    idx = CFG_IDX_W'(k);
                    case (idx) inside
                        REG_SHOCK_EN, REG_SAFE_MODE: begin
                            data = CFG_DATA_W'($urandom);
                        end
                        REG_TARGET: begin
                            data = CFG_DATA_W'($urandom);
                            case ($urandom_range(0, 7))
                                0:       data[TGT_W-1:0] = TGT_W'(1);
                                1:       data[TGT_W-1:0] = TGT_W'(SAFE_VOLTS);
                                2:       data[TGT_W-1:0] = TGT_W'(SAFE_VOLTS + 1);
                                3:       data[TGT_W-1:0] = TGT_W'(FULL_VOLTS);
                                4:       data[TGT_W-1:0] = TGT_W'(FULL_VOLTS + 1);
                                5:       data[TGT_W-1:0] = '1;
                                default: data[TGT_W-1:0] = TGT_W'($urandom);
                            endcase
                        end
                        default: begin
                            case ($urandom_range(0, 5))
                                0:       data = '0;
                                1:       data = '1;
                                2:       data = CFG_DATA_W'(256);
                                3:       data = CFG_DATA_W'($urandom_range(0, 63));
                                default: data = CFG_DATA_W'($urandom);
                            endcase
                        end
                    endcase
                    write_reg(idx, data);
                end
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
                          CFG_DATA_W'($urandom));

            if (kind == 0) begin
                data = CFG_DATA_W'($urandom);
                if ($urandom_range(0, 1) != 0) begin
                    data[0] = 1'b0;
                    write_reg(REG_SHOCK_EN, data);
                end else begin
                    data[TGT_W-1:0] = '0;
                    write_reg(REG_TARGET, data);
                end
                n = $urandom_range(5, 20);
            end else begin
                if (!cfg_shock) begin
                    data    = CFG_DATA_W'($urandom);
                    data[0] = 1'b1;
                    write_reg(REG_SHOCK_EN, data);
                end
                if (cfg_target == '0)
                    write_reg(REG_TARGET, CFG_DATA_W'($urandom_range(1, 127)));
                n = (kind <= 3) ? $urandom_range(30, 60) : $urandom_range(20, 80);
            end

            upward = $urandom_range(0, 1);
            repeat (n) begin
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                if (kind == 0) begin
                    s = ADC_BITS'($urandom);
                end else if (kind <= 3) begin
                    // push the integral toward one clamp, landing on it exactly when possible
                    if ($urandom_range(0, 24) == 0)
                        upward = !upward;
                    tgt256 = capped_target() * VOLT_ONE;
                    push_s = upward ? ADC_BITS'(0) : ADC_BITS'(ADC_MAX);
                    push   = tgt256 - sample_volts(push_s);
                    need   = (upward ? INT_CLAMP : -INT_CLAMP) - int'(pred_integral);
                    if (upward ? (need > push) : (need < push)) begin
                        s = ($urandom_range(0, 3) == 0) ? ADC_BITS'($urandom) : push_s;
                    end else begin
                        s     = push_s;
                        found = 1'b0;
                        if ($urandom_range(0, 2) != 0) begin
                            for (int k = 0; k <= ADC_MAX; k++) begin
                                if (!found && tgt256 - sample_volts(ADC_BITS'(k)) == need) begin
                                    s     = ADC_BITS'(k);
                                    found = 1'b1;
                                end
                            end
                        end
                        if (!found) begin
                            // no exact landing: take a random smaller step
                            hits = 0;
                            for (int k = 0; k <= ADC_MAX; k++) begin
                                err = tgt256 - sample_volts(ADC_BITS'(k));
                                if (upward ? (err > 0 && err < need) : (err < 0 && err > need))
                                    hits++;
                            end
                            if (hits != 0) begin
                                pick = $urandom_range(0, hits - 1);
                                for (int k = 0; k <= ADC_MAX; k++) begin
                                    err = tgt256 - sample_volts(ADC_BITS'(k));
                                    if (upward ? (err > 0 && err < need)
                                               : (err < 0 && err > need)) begin
                                        if (pick == 0)
                                            s = ADC_BITS'(k);
                                        pick--;
                                    end
                                end
                            end
                        end
                    end
                end else begin
                    case ($urandom_range(0, 7))
                        0: s = '0;
                        1: s = '1;
                        2, 3: begin
                            sp = capped_target() * VOLT_ONE * 1024 / COUNT_SCALE
                               + int'($urandom_range(0, 80)) - 40;
                            if (sp < 0)
                                sp = 0;
                            if (sp > ADC_MAX)
                                sp = ADC_MAX;
                            s = ADC_BITS'(sp);
                        end
                        default: s = ADC_BITS'($urandom);
                    endcase
                end
                send_sample(s, regulate_tick(s));
                items_sent++;
            end
        end

        idle_odds   = 0;
        i_cfg_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && duty_expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bpvr_pkg.sv
src/bpvr_cfg.sv
src/bpvr_ctrl.sv
src/bpvr_dp.sv
src/boost_pi_voltage_regulator.sv
src/bpvr_checker.sv
test/boost_pi_voltage_regulator_test.sv
